### src/nbe_pkg.sv
// shared constants and types for the neighbor bin enumerator
package nbe_pkg;

    localparam int CENTER_W     = 16;   // bin index width
    localparam int CFG_W        = 9;    // bins_per_side register width
    localparam int MAX_SIDE_DEF = 256;  // default largest grid side
    localparam int DIV_STEP     = 2;    // remainder bits resolved per divider stage

    // per-item status that rides along the pipeline
    typedef struct packed {
        logic bad;   // index outside the grid
        logic up;    // a row above exists
        logic down;  // a row below exists
    } nbe_flags_t;

endpackage

### src/nbe_div_stage.sv
// one pipeline stage of the restoring remainder unit (index mod side)
module nbe_div_stage
    import nbe_pkg::*;
#(
    parameter int SW     = 9,
    parameter int HI_BIT = CENTER_W - 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CENTER_W-1:0] in_center,
    input  logic [SW-1:0]       in_rem,
    input  nbe_flags_t          in_flags,
    input  logic [SW-1:0]       side,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CENTER_W-1:0] out_center,
    output logic [SW-1:0]       out_rem,
    output nbe_flags_t          out_flags
);

    logic                valid_reg;
    logic                valid_next;
    logic [CENTER_W-1:0] center_reg;
    logic [SW-1:0]       rem_reg;
    logic [SW-1:0]       rem_next;
    nbe_flags_t          flags_reg;
    logic                load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // shift in DIV_STEP dividend bits, conditional subtract after each
    always_comb begin
        logic [SW:0] r;
        r = {1'b0, in_rem};
        for (int i = 0; i < DIV_STEP; i++) begin
            r = {r[SW-1:0], in_center[HI_BIT - i]};
            if (r >= {1'b0, side}) begin
                r = r - {1'b0, side};
            end
        end
        rem_next = r[SW-1:0];
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            center_reg <= in_center;
            rem_reg    <= rem_next;
            flags_reg  <= in_flags;
        end
    end

    assign out_valid  = valid_reg;
    assign out_center = center_reg;
    assign out_rem    = rem_reg;
    assign out_flags  = flags_reg;

endmodule

### src/nbe_emit.sv
// walks the 3x3 neighborhood of one item and presents one index per cycle while m_ready is high
module nbe_emit
    import nbe_pkg::*;
#(
    parameter int SW = 9
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CENTER_W-1:0] in_center,
    input  logic [SW-1:0]       in_col,
    input  nbe_flags_t          in_flags,
    input  logic [SW-1:0]       side,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CENTER_W-1:0] m_index,
    output logic                m_last,
    output logic                m_bad
);

    logic                busy_reg, busy_next;
    logic [CENTER_W-1:0] cur_reg, cur_next;
    logic [CENTER_W-1:0] row_start_reg, row_start_next;
    logic [1:0]          col_cnt_reg, col_cnt_next;
    logic [1:0]          row_cnt_reg, row_cnt_next;
    logic [1:0]          cols_m1_reg, cols_m1_next;
    logic [1:0]          rows_m1_reg, rows_m1_next;
    logic                bad_reg, bad_next;

    logic                load;
    logic                advance;
    logic                last_now;
    logic                has_left;
    logic                has_right;
    logic [CENTER_W-1:0] side_w;
    logic [CENTER_W-1:0] start;

    assign side_w    = CENTER_W'(side);
    assign last_now  = (col_cnt_reg == cols_m1_reg) && (row_cnt_reg == rows_m1_reg);
    assign in_ready  = !busy_reg || (m_ready && last_now);
    assign load      = in_valid && in_ready;
    assign advance   = busy_reg && m_ready;
    assign has_left  = (in_col != '0);
    assign has_right = (in_col != (side - SW'(1)));

    // upper-left corner of the clipped neighborhood
    assign start = in_center - (in_flags.up ? side_w : '0)
                             - (has_left ? CENTER_W'(1) : '0);

    always_comb begin
        busy_next      = busy_reg;
        cur_next       = cur_reg;
        row_start_next = row_start_reg;
        col_cnt_next   = col_cnt_reg;
        row_cnt_next   = row_cnt_reg;
        cols_m1_next   = cols_m1_reg;
        rows_m1_next   = rows_m1_reg;
        bad_next       = bad_reg;
        if (advance) begin
            if (last_now) begin
                busy_next = 1'b0;
            end else if (col_cnt_reg == cols_m1_reg) begin
                col_cnt_next   = '0;
                row_cnt_next   = row_cnt_reg + 2'd1;
                row_start_next = row_start_reg + side_w;
                cur_next       = row_start_reg + side_w;
            end else begin
                col_cnt_next = col_cnt_reg + 2'd1;
                cur_next     = cur_reg + CENTER_W'(1);
            end
        end
        if (load) begin
            busy_next    = 1'b1;
            col_cnt_next = '0;
            row_cnt_next = '0;
            bad_next     = in_flags.bad;
            if (in_flags.bad) begin
                // single error result
                cur_next       = '0;
                row_start_next = '0;
                cols_m1_next   = '0;
                rows_m1_next   = '0;
            end else begin
                cur_next       = start;
                row_start_next = start;
                cols_m1_next   = {1'b0, has_left} + {1'b0, has_right};
                rows_m1_next   = {1'b0, in_flags.up} + {1'b0, in_flags.down};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        row_start_reg <= row_start_next;
        col_cnt_reg   <= col_cnt_next;
        row_cnt_reg   <= row_cnt_next;
        cols_m1_reg   <= cols_m1_next;
        rows_m1_reg   <= rows_m1_next;
        bad_reg       <= bad_next;
    end

    assign m_valid = busy_reg;
    assign m_index = cur_reg;
    assign m_last  = last_now;
    assign m_bad   = bad_reg;

`ifndef SYNTHESIS
    // an error item is one zero result
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && bad_reg |-> last_now && (cur_reg == '0))
        else $error("error item not a single zero result");

    // counters never run past the clipped extent
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (col_cnt_reg <= cols_m1_reg) && (row_cnt_reg <= rows_m1_reg)
                     && (cols_m1_reg != 2'd3) && (rows_m1_reg != 2'd3))
        else $error("neighborhood counter out of range");

    // after the final result goes out with nothing waiting, the walker goes idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && m_ready && last_now && !in_valid |=> !busy_reg)
        else $error("walker did not release after final result");

    // a non-final handoff moves by one column or one row
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && m_ready && !last_now |=> busy_reg
            && ((cur_reg == $past(cur_reg) + CENTER_W'(1))
                || (cur_reg == $past(row_start_reg) + side_w)))
        else $error("neighbor index stepped wrongly");
`endif

endmodule

### src/neighbor_bin_enumerator_2d.sv
// top level: 3x3 neighborhood enumeration over a square bin grid
//
// s_tdata carries the linear index of a bin (column + row * side). for each
// item the block sends, on the m_ channel, the linear indices of the up to
// nine grid bins around it, row-major from upper-left to lower-right, the bin
// itself included; m_tlast marks the final one. an index at or beyond
// side*side gives one result of zero with m_tuser (bad index) and m_tlast set.
// cfg_wr_en/cfg_wr_data set bins_per_side (0 acts as 1, values above MAX_SIDE
// act as MAX_SIDE); write it only with the block idle.
// the first result follows the input register, 8 remainder stages at 2 bits each
// and the neighborhood walker.
// throughput: one result per cycle while m_tready is high; an item gives 1, 4, 6
// or 9 results depending on how many neighbors lie inside the grid, and the
// walker's one-result-per-cycle output sets the sustained rate.
// reset (aresetn low, synchronous) empties the pipeline and sets the side
// to 1. when m_tready is low the walker holds its result and the stages
// behind it fill up and then drop s_tready; nothing is lost or repeated.
module neighbor_bin_enumerator_2d
    import nbe_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,   // bins_per_side
    // query items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CENTER_W-1:0] s_tdata,       // [15:0] center_bin
    // neighbor items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [CENTER_W-1:0] m_tdata,       // [15:0] neighbor_bin
    output logic                m_tlast,       // last_neighbor
    output logic [0:0]          m_tuser        // [0] bad_index
);

    localparam int SW   = $clog2(MAX_SIDE + 1);            // side width
    localparam int CW   = (SW > CFG_W) ? SW : CFG_W;       // clamp compare width
    localparam int SQW  = 2 * SW;                          // side squared width
    localparam int XW   = (SQW > CENTER_W) ? SQW : CENTER_W;
    localparam int NSTG = CENTER_W / DIV_STEP;             // remainder stages

    localparam logic [CW-1:0] MAX_SIDE_C = CW'(MAX_SIDE);

    // configuration and derived grid sizes
    logic [CFG_W-1:0] cfg_reg;
    logic [SW-1:0]    side_reg;
    logic [SQW-1:0]   side_sq_reg;
    logic [SQW-1:0]   side_dn_reg;    // side * (side - 1): first index of the bottom row
    logic [CW-1:0]    cfg_ext;
    logic [SW-1:0]    side_clamp;

    assign cfg_ext = CW'(cfg_reg);

    always_comb begin
        if (cfg_reg == '0) begin
            side_clamp = SW'(1);
        end else if (cfg_ext > MAX_SIDE_C) begin
            side_clamp = SW'(MAX_SIDE_C);
        end else begin
            side_clamp = SW'(cfg_ext);
        end
    end

    // derived sizes follow the register in the next cycle; an item passes the input
    // register before any stage looks at them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= CFG_W'(1);
            side_reg    <= SW'(1);
            side_sq_reg <= SQW'(1);
            side_dn_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            side_reg    <= side_clamp;
            side_sq_reg <= SQW'(side_clamp) * SQW'(side_clamp);
            side_dn_reg <= SQW'(side_clamp) * SQW'(side_clamp - SW'(1));
        end
    end

    // input register
    logic                in_valid_reg;
    logic [CENTER_W-1:0] in_center_reg;
    logic [XW-1:0]       center_x;

    logic [NSTG:0]       v_w;
    logic [NSTG:0]       r_w;
    logic [CENTER_W-1:0] c_w   [NSTG+1];
    logic [SW-1:0]       rem_w [NSTG+1];
    nbe_flags_t          f_w   [NSTG+1];

    assign s_tready = !in_valid_reg || r_w[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_center_reg <= s_tdata;
        end
    end

    // row tests need no row number: compare the index against row boundaries
    assign center_x   = XW'(in_center_reg);
    assign v_w[0]     = in_valid_reg;
    assign c_w[0]     = in_center_reg;
    assign rem_w[0]   = '0;
    assign f_w[0].bad  = (center_x >= XW'(side_sq_reg));
    assign f_w[0].up   = (center_x >= XW'(side_reg));
    assign f_w[0].down = (center_x < XW'(side_dn_reg));

    // remainder pipeline: column = index mod side
    for (genvar k = 0; k < NSTG; k++) begin : g_div
        nbe_div_stage #(
            .SW     (SW),
            .HI_BIT (CENTER_W - 1 - k * DIV_STEP)
        ) u_stage (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .in_valid   (v_w[k]),
            .in_ready   (r_w[k]),
            .in_center  (c_w[k]),
            .in_rem     (rem_w[k]),
            .in_flags   (f_w[k]),
            .side       (side_reg),
            .out_valid  (v_w[k+1]),
            .out_ready  (r_w[k+1]),
            .out_center (c_w[k+1]),
            .out_rem    (rem_w[k+1]),
            .out_flags  (f_w[k+1])
        );
    end

    // neighborhood walker doubles as the output register
    nbe_emit #(
        .SW (SW)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v_w[NSTG]),
        .in_ready  (r_w[NSTG]),
        .in_center (c_w[NSTG]),
        .in_col    (rem_w[NSTG]),
        .in_flags  (f_w[NSTG]),
        .side      (side_reg),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_index   (m_tdata),
        .m_last    (m_tlast),
        .m_bad     (m_tuser[0])
    );

endmodule
